[design/assert_macros.svh]
// Assertion macros shared by the console writer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check held off while reset is asserted.
`define TCW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that also holds during reset.
`define TCW_ASSERT_RST(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[design/tcw_pkg.sv]
// Types and constants for the text console writer.
// No dependencies; imported by tcw_engine and text_console_writer.
package tcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int TAB_STEP = 8;

    localparam logic       CMD_PUT  = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic       REG_FG = 1'b0;
    localparam logic       REG_BG = 1'b1;

    typedef struct packed {
        logic             command;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attrib;
    } t_out_item;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_eng_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK,
        ST_PUTC,
        ST_RDATA,
        ST_EMIT
    } t_eng_state;

endpackage

[design/tcw_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tcw_engine.sv]
// Console sequencer: cursor logic, cell RAM clear, scroll copy and cell access.
// Depends on tcw_pkg and tcw_ram.
module tcw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tcw_pkg::t_in_item   i_in_data,
    input  logic [7:0]          i_attrib,
    input  logic                i_res_take,
    output logic                o_res_valid,
    output tcw_pkg::t_out_item  o_res,
    output tcw_pkg::t_eng_status o_status
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    t_eng_state         r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic               r_cp_valid;
    logic [AW-1:0]      r_cp_dst;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pend_addr, n_pend_addr;
    logic [CELL_W-1:0]  r_pend_data, n_pend_data;
    logic               r_rd_hit, n_rd_hit;
    logic [CELL_W-1:0]  r_cell, n_cell;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [CELL_W-1:0]  w_rdata;

    logic               w_accept;
    logic [7:0]         w_ch;
    logic               w_cr, w_lf, w_bs, w_ht, w_print;
    logic               w_wrap, w_last_row, w_scroll;
    logic [COL_W-1:0]   w_c1, w_c2;
    logic [ROW_W-1:0]   w_r1;
    logic [7:0]         w_tab;
    logic [AW-1:0]      w_put_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    // put-byte decode against the current cursor
    always_comb begin
        w_ch       = i_in_data.char_code;
        w_cr       = (w_ch == CH_CR);
        w_lf       = (w_ch == CH_LF);
        w_bs       = (w_ch == CH_BS);
        w_ht       = (w_ch == CH_HT);
        w_print    = !w_ch[7] && (w_ch[6:5] != 2'b00);
        w_wrap     = !w_cr && ((32'(r_col) >= COLUMNS) || w_lf);
        w_last_row = (32'(r_row) + 32'd1 >= ROWS);
        w_scroll   = w_wrap && w_last_row;
        w_c1       = w_wrap ? '0 : r_col;
        w_r1       = (w_wrap && !w_last_row) ? r_row + 5'd1 : r_row;
        w_tab      = (8'(w_c1) + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
        w_put_addr = AW'(32'(w_r1) * COLUMNS + 32'(w_c1));
        if (w_cr) begin
            w_c2 = '0;
        end else if (w_lf) begin
            w_c2 = w_c1;
        end else if (w_bs) begin
            w_c2 = (w_c1 != '0) ? w_c1 - 7'd1 : w_c1;
        end else if (w_ht) begin
            w_c2 = (32'(w_tab) > COLUMNS) ? COL_W'(COLUMNS) : w_tab[COL_W-1:0];
        end else if (w_print) begin
            w_c2 = w_c1 + 7'd1;
        end else begin
            w_c2 = w_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_col      <= '0;
            r_row      <= '0;
            r_cnt      <= '0;
            r_cp_valid <= 1'b0;
            r_pend     <= 1'b0;
            r_rd_hit   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_cnt      <= n_cnt;
            r_cp_valid <= (r_state == ST_SCROLL);
            r_pend     <= n_pend;
            r_rd_hit   <= n_rd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_dst    <= r_cnt - AW'(COLUMNS);
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
        r_cell      <= n_cell;
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_pend_data = r_pend_data;
        n_rd_hit    = r_rd_hit;
        n_cell      = r_cell;
        w_we        = 1'b0;
        w_waddr     = r_cnt;
        w_wdata     = '0;
        w_raddr     = r_cnt;
        o_res_valid = 1'b0;

        // trailing copy write of the scroll pipeline
        if (r_cp_valid) begin
            w_we    = 1'b1;
            w_waddr = r_cp_dst;
            w_wdata = w_rdata;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = '0;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.command == CMD_READ) begin
                        w_raddr  = AW'(i_in_data.cell_index);
                        n_rd_hit = (32'(i_in_data.cell_index) < CELLS);
                        n_state  = ST_RDATA;
                    end else begin
                        n_col  = w_c2;
                        n_row  = w_r1;
                        n_cell = '0;
                        if (w_scroll) begin
                            n_pend      = w_print && !w_lf;
                            n_pend_addr = w_put_addr;
                            n_pend_data = {i_attrib, w_ch};
                            n_cnt       = AW'(COLUMNS);
                            n_state     = ST_SCROLL;
                        end else begin
                            w_we    = w_print && !w_cr && !w_lf;
                            w_waddr = w_put_addr;
                            w_wdata = {i_attrib, w_ch};
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_SCROLL: begin
                w_raddr = r_cnt;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt   = AW'(CELLS - COLUMNS);
                    n_state = ST_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_BLANK: begin
                if (!r_cp_valid) begin
                    w_we    = 1'b1;
                    w_waddr = r_cnt;
                    w_wdata = '0;
                    if (r_cnt == AW'(CELLS - 1)) begin
                        n_cnt   = '0;
                        n_state = r_pend ? ST_PUTC : ST_EMIT;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_PUTC: begin
                w_we    = 1'b1;
                w_waddr = r_pend_addr;
                w_wdata = r_pend_data;
                n_pend  = 1'b0;
                n_state = ST_EMIT;
            end
            ST_RDATA: begin
                n_cell  = r_rd_hit ? w_rdata : '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.cursor_col  = r_col;
    assign o_res.cursor_row  = r_row;
    assign o_res.cell_char   = r_cell[7:0];
    assign o_res.cell_attrib = r_cell[15:8];

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_status.busy     = (r_state != ST_IDLE);

endmodule

[design/text_console_writer.sv]
// Text console writer top level: APB color registers, input/output channels, engine.
// Depends on tcw_pkg, tcw_engine, tcw_ram and assert_macros.svh.
//
// Text-mode console on a simple dual-port ROWS x COLUMNS cell RAM (16 bits per cell,
// attribute in the high byte). After reset the RAM is swept to zero, one cell
// a cycle, before the first transaction is taken. A put transaction moves from
// idle to the emit state, a read passes through a read-data state first. A
// put that wraps past the last row scrolls by copying the RAM one cell a cycle
// and blanking the last row; when the wrapping byte is printable it is written
// after the blanking. Each input transaction yields one result, held in an
// output register so the next input can be taken while the result waits.
// Color registers: foreground at 0x0, background at 0x4.
`include "assert_macros.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcw_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcw_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tcw_pkg::*;

    logic [3:0]   r_fg;
    logic [3:0]   r_bg;
    logic         r_out_valid;
    t_out_item    r_out;
    logic         w_cfg_wr;
    logic         w_res_valid;
    logic         w_res_take;
    t_out_item    w_res;
    t_eng_status  w_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_BG) ? {28'd0, r_bg} : {28'd0, r_fg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'hF;
            r_bg <= 4'h0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_FG: r_fg <= pwdata[3:0];
                REG_BG: r_bg <= pwdata[3:0];
                default: r_fg <= r_fg;
            endcase
        end
    end

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_attrib    ({r_bg, r_fg}),
        .i_res_take  (w_res_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_status    (w_stat)
    );

    assign o_in_stall = w_stat.busy;
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TCW_ASSERT_RST(a_clear_after_reset, i_clk, !i_rst_n |=> o_in_stall, "input taken during clear")
    `TCW_ASSERT(a_no_result_in_clear, i_clk, i_rst_n, w_stat.clearing |-> !o_out_valid, "result during clear")
    `TCW_ASSERT(a_cursor_range, i_clk, i_rst_n, o_out_valid |-> (32'(o_out_data.cursor_row) < ROWS) && (32'(o_out_data.cursor_col) <= COLUMNS), "cursor out of range")

endmodule
